[hdl/assert_macros.svh]
// Assertion macros used by the stream group reverser RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SGR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgr assertion failed");

`endif

[hdl/sgr_pkg.sv]
// Package of the stream group reverser: payload types, sizes and states.
// Depends on nothing; used by the core and the testbench.
`timescale 1ns / 1ps

package sgr_pkg;

   localparam int MAX_GROUP = 16;
   localparam int ADDR_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int CNT_W = $clog2(MAX_GROUP + 1);
   localparam int VALUE_W = 32;
   localparam int SIZE_W = 5;

   typedef struct packed {
      logic signed [VALUE_W-1:0] item_value;
      logic                      item_last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] out_value;
      logic                      out_last;
   } rsp_type;

   typedef enum logic {
      ST_ACCEPT,
      ST_DRAIN
   } state_type;

   function automatic logic [CNT_W-1:0] effective_size(input logic [SIZE_W-1:0] g);
      logic [CNT_W-1:0] r;
      if (g == '0) begin
         r = CNT_W'(1);
      end else if (32'(g) > MAX_GROUP) begin
         r = CNT_W'(MAX_GROUP);
      end else begin
         r = CNT_W'(g);
      end
      return r;
   endfunction

endpackage

[hdl/stream_group_reverser_core.sv]
// Stream group reverser: buffers requests in a group RAM and emits each group.
// Depends on sgr_pkg, sgr_ram and assert_macros.svh.
`timescale 1ns / 1ps
//
// Requests arrive on req_valid/req_stall/req_data and results leave on
// rsp_valid/rsp_stall/rsp_data; a transfer happens when valid is high and
// stall is low. The group size is written through csr_wr_en/csr_wr_data;
// the user must write it only while the block is idle, and the block
// itself does not enforce this. Zero counts as one and values above the
// store depth count as the depth. Each request is written into the group
// RAM. A request that fills the group, or that carries item_last, starts a
// drain: req_stall is held high while the buffered requests are read back,
// reversed for a full group and in arrival order for a short final group.
// After the request that starts the drain, each result passes through the
// registered RAM read and then the single output register; a new RAM read
// is issued only once the previous read has reached the output register.
// When the receiver stalls, the output register holds its result and no
// further RAM read is issued until it is taken. Once the last read of a
// drain is issued, new requests are taken again.
// Reset clears the fill count, the drain state and the output valid and sets
// the group size to two. The RAM needs no clearing.

`include "assert_macros.svh"

module stream_group_reverser_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  sgr_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output sgr_pkg::rsp_type             rsp_data,
   input  logic                         csr_wr_en,
   input  logic [sgr_pkg::SIZE_W-1:0]   csr_wr_data
);

   sgr_pkg::state_type             state_ff, state_in;
   logic [sgr_pkg::SIZE_W-1:0]     group_size_ff;
   logic [sgr_pkg::ADDR_W-1:0]     fill_ff, fill_in;
   logic [sgr_pkg::CNT_W-1:0]      left_ff, left_in;
   logic [sgr_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic                           rev_ff, rev_in;
   logic                           end_last_ff, end_last_in;
   logic                           rd_pending_ff;
   logic                           rd_last_ff, rd_last_in;
   logic                           rsp_valid_ff;
   sgr_pkg::rsp_type               rsp_data_ff;

   logic [sgr_pkg::CNT_W-1:0]      gsize;
   logic [sgr_pkg::CNT_W-1:0]      next_count;
   logic                           ram_wr_en;
   logic                           ram_rd_en;
   logic [sgr_pkg::VALUE_W-1:0]    ram_rd_data;

   assign gsize = sgr_pkg::effective_size(group_size_ff);
   assign next_count = sgr_pkg::CNT_W'(fill_ff) + sgr_pkg::CNT_W'(1);

   sgr_ram #(
      .WIDTH (sgr_pkg::VALUE_W),
      .DEPTH (sgr_pkg::MAX_GROUP)
   ) u_group_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (fill_ff),
      .wr_data (req_data.item_value),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgr_pkg::ST_ACCEPT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      left_in     = left_ff;
      addr_in     = addr_ff;
      rev_in      = rev_ff;
      end_last_in = end_last_ff;
      rd_last_in  = 1'b0;
      ram_rd_en   = 1'b0;
      req_stall   = (state_ff != sgr_pkg::ST_ACCEPT);
      ram_wr_en   = req_valid && !req_stall;
      unique case (state_ff)
         sgr_pkg::ST_ACCEPT: begin
            if (ram_wr_en) begin
               if (next_count >= gsize) begin
                  state_in    = sgr_pkg::ST_DRAIN;
                  left_in     = next_count;
                  addr_in     = sgr_pkg::ADDR_W'(next_count - sgr_pkg::CNT_W'(1));
                  rev_in      = 1'b1;
                  end_last_in = req_data.item_last;
                  fill_in     = '0;
               end else if (req_data.item_last) begin
                  state_in    = sgr_pkg::ST_DRAIN;
                  left_in     = next_count;
                  addr_in     = '0;
                  rev_in      = 1'b0;
                  end_last_in = 1'b1;
                  fill_in     = '0;
               end else begin
                  fill_in = sgr_pkg::ADDR_W'(next_count);
               end
            end
         end
         sgr_pkg::ST_DRAIN: begin
            if (!rd_pending_ff && (!rsp_valid_ff || !rsp_stall)) begin
               ram_rd_en = 1'b1;
               left_in   = left_ff - sgr_pkg::CNT_W'(1);
               addr_in   = rev_ff ? addr_ff - sgr_pkg::ADDR_W'(1)
                                  : addr_ff + sgr_pkg::ADDR_W'(1);
               if (left_ff == sgr_pkg::CNT_W'(1)) begin
                  rd_last_in = end_last_ff;
                  state_in   = sgr_pkg::ST_ACCEPT;
               end
            end
         end
         default: begin
            state_in = sgr_pkg::ST_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= sgr_pkg::SIZE_W'(2);
         fill_ff       <= '0;
         left_ff       <= '0;
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            group_size_ff <= csr_wr_data;
         end
         fill_ff       <= fill_in;
         left_ff       <= left_in;
         rd_pending_ff <= ram_rd_en;
         if (rd_pending_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      rev_ff      <= rev_in;
      end_last_ff <= end_last_in;
      rd_last_ff  <= rd_last_in;
      if (rd_pending_ff) begin
         rsp_data_ff.out_value <= signed'(ram_rd_data);
         rsp_data_ff.out_last  <= rd_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SGR_ASSERT_SAME(a_read_slot_free, clock, reset, rd_pending_ff, !rsp_valid_ff)
   `SGR_ASSERT_SAME(a_drain_has_work, clock, reset,
      state_ff == sgr_pkg::ST_DRAIN, left_ff != '0)
   `SGR_ASSERT_NEXT(a_no_read_after_req, clock, reset,
      req_valid && !req_stall, !rd_pending_ff)

endmodule

[hdl/sgr_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing; instanced by the stream group reverser core.
`timescale 1ns / 1ps

module sgr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[verif/tb_stream_group_reverser_core.sv]
// Self-checking testbench for stream_group_reverser_core: directed table plus random streams.
// Depends on sgr_pkg and the core RTL; predicts each group's reordering and checks every result.
`timescale 1ns / 1ps

module tb_stream_group_reverser_core;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_PAUSE = 6;
   localparam int RANDOM_REQUESTS = 400;

   typedef struct packed {
      logic        wr_size;
      logic [4:0]  size;
      logic [31:0] value;
      logic        last;
      logic        typed;
      logic [31:0] exp_value;
      logic        exp_last;
   } stim_row_type;

   localparam int NUM_ROWS = 17;
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{1'b0, 5'd0,  32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b0, 5'd0,  32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b0, 5'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1},
      '{1'b1, 5'd1,  32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
      '{1'b0, 5'd0,  32'h5555_5555, 1'b1, 1'b1, 32'h5555_5555, 1'b1},
      '{1'b1, 5'd0,  32'hAAAA_AAAA, 1'b0, 1'b1, 32'hAAAA_AAAA, 1'b0},
      '{1'b1, 5'd17, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b0, 5'd0,  32'hFFFF_FFFE, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b1, 5'd4,  32'h1111_1111, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b0, 5'd0,  32'h2222_2222, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b0, 5'd0,  32'h3333_3333, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b1, 5'd2,  32'h4444_4444, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b1, 5'd3,  32'hC0DE_F00D, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b0, 5'd0,  32'h0123_4567, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b0, 5'd0,  32'h8000_0001, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{1'b1, 5'd16, 32'h7FFF_FFFE, 1'b1, 1'b1, 32'h7FFF_FFFE, 1'b1},
      '{1'b1, 5'd31, 32'h0F0F_0F0F, 1'b1, 1'b1, 32'h0F0F_0F0F, 1'b1}
   };

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   sgr_pkg::req_type           req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   sgr_pkg::rsp_type           rsp_data;
   logic                       csr_wr_en = 1'b0;
   logic [sgr_pkg::SIZE_W-1:0] csr_wr_data = '0;

   logic [31:0]      group_words [sgr_pkg::MAX_GROUP];
   int               fill_q = 0;
   logic [4:0]       group_size_q = 5'd2;
   sgr_pkg::rsp_type pending_results [$];

   int               mismatch_count = 0;
   int               requests_sent = 0;
   int               cycle_count = 0;
   bit               no_idle = 1'b0;

   stream_group_reverser_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void predict_request(input sgr_pkg::req_type r);
      int               span;
      int               n;
      int               k;
      sgr_pkg::rsp_type e;
      if (group_size_q == 5'd0) begin
         span = 1;
      end else if (int'(group_size_q) > sgr_pkg::MAX_GROUP) begin
         span = sgr_pkg::MAX_GROUP;
      end else begin
         span = int'(group_size_q);
      end
      if (fill_q >= sgr_pkg::MAX_GROUP) begin
         fill_q = 0;
      end
      group_words[fill_q] = r.item_value;
      fill_q++;
      n = fill_q;
      if (n >= span) begin
         for (k = 0; k < n; k++) begin
            e.out_value = group_words[n - 1 - k];
            e.out_last = (k == n - 1) ? r.item_last : 1'b0;
            pending_results.push_back(e);
         end
         fill_q = 0;
      end else if (r.item_last) begin
         for (k = 0; k < n; k++) begin
            e.out_value = group_words[k];
            e.out_last = (k == n - 1);
            pending_results.push_back(e);
         end
         fill_q = 0;
      end
   endfunction

   task automatic drive_request(input sgr_pkg::req_type r, input bit typed,
                                input sgr_pkg::rsp_type typed_rsp);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      predict_request(r);
      if (typed) begin
         void'(pending_results.pop_back());
         pending_results.push_back(typed_rsp);
      end
      requests_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic write_group_size(input logic [4:0] v);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      group_size_q = v;
   endtask

   initial begin : rsp_side
      int hold;
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 13);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      sgr_pkg::rsp_type oldest;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result: expected none, actual value %h last %0b",
                     $time, rsp_data.out_value, rsp_data.out_last);
            mismatch_count++;
         end else begin
            oldest = pending_results.pop_front();
            if (oldest.out_value !== rsp_data.out_value ||
                oldest.out_last !== rsp_data.out_last) begin
               $display("%0t result mismatch: expected value %h last %0b, actual value %h last %0b",
                        $time, oldest.out_value, oldest.out_last,
                        rsp_data.out_value, rsp_data.out_last);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      sgr_pkg::req_type r;
      sgr_pkg::rsp_type t;
      int               len;
      int               i;
      bit               close_stream;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_ROWS; i++) begin
         if (DIRECTED_ROWS[i].wr_size) begin
            write_group_size(DIRECTED_ROWS[i].size);
         end
         r.item_value = DIRECTED_ROWS[i].value;
         r.item_last = DIRECTED_ROWS[i].last;
         t.out_value = DIRECTED_ROWS[i].exp_value;
         t.out_last = DIRECTED_ROWS[i].exp_last;
         drive_request(r, DIRECTED_ROWS[i].typed, t);
      end

      // Streams that stop without a last element leave a partial group behind, so the
      // next size write may land in the middle of a group.
      while (requests_sent < NUM_ROWS + RANDOM_REQUESTS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0: write_group_size(5'd1);
               1: write_group_size(5'd16);
               2: write_group_size(5'd0);
               3: write_group_size(5'd31);
               4: write_group_size(5'($urandom_range(17, 30)));
               default: write_group_size(5'($urandom_range(1, 16)));
            endcase
         end
         len = $urandom_range(1, 40);
         close_stream = ($urandom_range(0, 3) != 0);
         for (i = 0; i < len; i++) begin
            case ($urandom_range(0, 7))
               0: r.item_value = 32'h7FFF_FFFF;
               1: r.item_value = 32'h8000_0000;
               2: r.item_value = '0;
               3: r.item_value = '1;
               default: r.item_value = $urandom;
            endcase
            r.item_last = (i == len - 1) ? close_stream : ($urandom_range(0, 31) == 0);
            drive_request(r, 1'b0, '0);
         end
      end

      no_idle = 1'b0;
      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
